>>> rtl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge once reset is released.
`define BPC_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("bpc_checker: property failed");

// Check on every clock edge, reset cycles included.
`define BPC_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("bpc_checker: property failed");

`endif

>>> rtl/bpc_pkg.sv
`timescale 1ns / 1ps

package bpc_pkg;

    localparam int DATA_W   = 24;
    localparam int COEF_W   = 16;
    localparam int DT_W     = 26;
    localparam int MUL_A_W  = 35;
    localparam int MUL_HI_W = 36;
    localparam int PROD_W   = 60;
    localparam int LEN_W    = 5;
    localparam int TEMP_W   = 21;
    localparam int OFF_W    = 35;
    localparam int PSH_W    = 37;
    localparam int DIFF_W   = 38;
    localparam int PRESS_W  = 23;
    localparam int KSUM_W   = 16;
    localparam int KPROD_W  = 29;
    localparam int ADDR_W   = 5;

    localparam logic [LEN_W-1:0] COEF_LEN = 5'd16;
    localparam logic [LEN_W-1:0] RAW_LEN  = 5'd24;

    localparam logic signed [TEMP_W-1:0]  TEMP_BASE   = 21'sd2000;
    localparam logic signed [TEMP_W-1:0]  TEMP_LO     = -21'sd4000;
    localparam logic signed [TEMP_W-1:0]  TEMP_HI     = 21'sd8500;
    localparam logic signed [TEMP_W-1:0]  KELVIN_BIAS = 21'sd27365;
    localparam logic signed [PRESS_W-1:0] PRESS_LO    = 23'sd45000;
    localparam logic signed [PRESS_W-1:0] PRESS_HI    = 23'sd120000;
    // floor(x / 100) == (x * 5243) >> 19 for every x below 43690
    localparam logic [12:0] RECIP_100 = 13'd5243;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_T,
        ST_MUL_O,
        ST_MUL_S,
        ST_MUL_P,
        ST_CHECK,
        ST_KELV
    } seq_state_t;

    typedef enum logic [2:0] {
        REG_C1,
        REG_C2,
        REG_C3,
        REG_C4,
        REG_C5,
        REG_C6
    } reg_idx_t;

    typedef struct packed {
        logic [COEF_W-1:0] c1;
        logic [COEF_W-1:0] c2;
        logic [COEF_W-1:0] c3;
        logic [COEF_W-1:0] c4;
        logic [COEF_W-1:0] c5;
        logic [COEF_W-1:0] c6;
    } coef_t;

    typedef struct packed {
        logic             start;
        logic [LEN_W-1:0] len;
    } mul_ctrl_t;

    typedef struct packed {
        logic [16:0] pressure_pa;
        logic [14:0] temp_centi;
        logic [8:0]  temp_kelvin;
    } result_t;

endpackage

>>> rtl/bpc_apb_regs.sv
`timescale 1ns / 1ps

module bpc_apb_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bpc_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output bpc_pkg::coef_t              coef
);
    import bpc_pkg::*;

    coef_t    coef_reg, coef_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign coef   = coef_reg;

    always_comb begin
        coef_next = coef_reg;
        if (wr_en) begin
            case (idx)
                REG_C1:  coef_next.c1 = pwdata[COEF_W-1:0];
                REG_C2:  coef_next.c2 = pwdata[COEF_W-1:0];
                REG_C3:  coef_next.c3 = pwdata[COEF_W-1:0];
                REG_C4:  coef_next.c4 = pwdata[COEF_W-1:0];
                REG_C5:  coef_next.c5 = pwdata[COEF_W-1:0];
                REG_C6:  coef_next.c6 = pwdata[COEF_W-1:0];
                default: coef_next = coef_reg;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_C1:  prdata = {16'h0000, coef_reg.c1};
            REG_C2:  prdata = {16'h0000, coef_reg.c2};
            REG_C3:  prdata = {16'h0000, coef_reg.c3};
            REG_C4:  prdata = {16'h0000, coef_reg.c4};
            REG_C5:  prdata = {16'h0000, coef_reg.c5};
            REG_C6:  prdata = {16'h0000, coef_reg.c6};
            default: prdata = 32'h0000_0000;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg <= '0;
        end else begin
            coef_reg <= coef_next;
        end
    end

endmodule

>>> rtl/bpc_serial_mul.sv
`timescale 1ns / 1ps

// Shift-add multiplier: signed multiplicand, unsigned multiplier, one bit per cycle.
// After len steps the 60-bit product register holds a * b * 2^(24 - len).
module bpc_serial_mul (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  bpc_pkg::mul_ctrl_t                  ctrl,
    input  logic signed [bpc_pkg::MUL_A_W-1:0]  mul_a,
    input  logic [bpc_pkg::DATA_W-1:0]          mul_b,
    output logic                                mul_done,
    output logic [bpc_pkg::PROD_W-1:0]          product
);
    import bpc_pkg::*;

    logic [MUL_HI_W-1:0] hi_reg, hi_next;
    logic [DATA_W-1:0]   lo_reg, lo_next;
    logic [MUL_A_W-1:0]  a_reg, a_next;
    logic [LEN_W-1:0]    cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [MUL_HI_W-1:0] sum;

    assign sum      = hi_reg + (lo_reg[0] ? {a_reg[MUL_A_W-1], a_reg} : '0);
    assign product  = {hi_reg, lo_reg};
    assign mul_done = done_reg;

    always_comb begin
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        a_next    = a_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctrl.start) begin
            hi_next   = '0;
            lo_next   = mul_b;
            a_next    = mul_a;
            cnt_next  = ctrl.len;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // add, then shift the whole product right by one, keeping the sign
            hi_next  = {sum[MUL_HI_W-1], sum[MUL_HI_W-1:1]};
            lo_next  = {sum[0], lo_reg[DATA_W-1:1]};
            cnt_next = cnt_reg - LEN_W'(1);
            if (cnt_reg == LEN_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        hi_reg <= hi_next;
        lo_reg <= lo_next;
        a_reg  <= a_next;
    end

endmodule

>>> rtl/bpc_seq.sv
`timescale 1ns / 1ps

module bpc_seq (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [bpc_pkg::DATA_W-1:0]          d1_in,
    input  logic [bpc_pkg::DATA_W-1:0]          d2_in,
    input  logic                                tv_in,
    input  bpc_pkg::coef_t                      coef,
    output bpc_pkg::mul_ctrl_t                  mul_ctrl,
    output logic signed [bpc_pkg::MUL_A_W-1:0]  mul_a,
    output logic [bpc_pkg::DATA_W-1:0]          mul_b,
    input  logic                                mul_done,
    input  logic [bpc_pkg::PROD_W-1:0]          product,
    output logic                                res_valid,
    input  logic                                res_ready,
    output bpc_pkg::result_t                    result
);
    import bpc_pkg::*;

    seq_state_t state_reg, state_next;

    logic signed [DT_W-1:0]    dt_reg, dt_next;
    logic                      seen_reg, seen_next;
    logic [DATA_W-1:0]         d1_reg;
    logic signed [TEMP_W-1:0]  temp_reg;
    logic [OFF_W-1:0]          off_reg;
    logic [PSH_W-1:0]          psh_reg;
    logic [16:0]               press_reg;
    logic [14:0]               tout_reg;
    logic [KSUM_W-1:0]         ksum_reg;

    logic                      in_acc;
    logic [MUL_A_W-1:0]        dt_ext, dt_next_ext;
    logic [MUL_A_W-1:0]        sens_next;
    logic [DIFF_W-1:0]         press_diff;
    logic signed [PRESS_W-1:0] press_val;
    logic signed [TEMP_W-1:0]  ksum;
    logic                      in_window;
    logic [KPROD_W-1:0]        kprod;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_acc   = in_valid && in_ready;

    // datapath
    always_comb begin
        dt_next   = dt_reg;
        seen_next = seen_reg;
        if (in_acc && tv_in) begin
            dt_next   = {2'b00, d2_in} - {2'b00, coef.c5, 8'h00};
            seen_next = 1'b1;
        end
        dt_ext      = {{(MUL_A_W-DT_W){dt_reg[DT_W-1]}}, dt_reg};
        dt_next_ext = {{(MUL_A_W-DT_W){dt_next[DT_W-1]}}, dt_next};
        // product of a 16-step run carries an extra factor of 2^8
        sens_next   = {4'h0, coef.c1, 15'h0000} + {product[49], product[49:16]};
        press_diff  = {psh_reg[PSH_W-1], psh_reg} - {{3{off_reg[OFF_W-1]}}, off_reg};
        press_val   = press_diff[DIFF_W-1:15];
        ksum        = temp_reg + KELVIN_BIAS;
        in_window   = (press_val > PRESS_LO) && (press_val < PRESS_HI) &&
                      (temp_reg > TEMP_LO) && (temp_reg < TEMP_HI);
        kprod       = KPROD_W'(ksum_reg) * KPROD_W'(RECIP_100);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc && seen_next) state_next = ST_MUL_T;
            end
            ST_MUL_T: begin
                if (mul_done) state_next = ST_MUL_O;
            end
            ST_MUL_O: begin
                if (mul_done) state_next = ST_MUL_S;
            end
            ST_MUL_S: begin
                if (mul_done) state_next = ST_MUL_P;
            end
            ST_MUL_P: begin
                if (mul_done) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                state_next = in_window ? ST_KELV : ST_IDLE;
            end
            ST_KELV: begin
                if (res_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        res_valid      = 1'b0;
        mul_ctrl.start = 1'b0;
        mul_ctrl.len   = COEF_LEN;
        mul_a          = dt_ext;
        mul_b          = {8'h00, coef.c6};
        case (state_reg)
            ST_IDLE: begin
                mul_ctrl.start = in_acc && seen_next;
                mul_a          = dt_next_ext;
            end
            ST_MUL_T: begin
                mul_ctrl.start = mul_done;
                mul_b          = {8'h00, coef.c4};
            end
            ST_MUL_O: begin
                mul_ctrl.start = mul_done;
                mul_b          = {8'h00, coef.c3};
            end
            ST_MUL_S: begin
                mul_ctrl.start = mul_done;
                mul_ctrl.len   = RAW_LEN;
                mul_a          = sens_next;
                mul_b          = d1_reg;
            end
            ST_KELV: begin
                res_valid = 1'b1;
            end
            default: begin
                res_valid = 1'b0;
            end
        endcase
    end

    assign result.pressure_pa = press_reg;
    assign result.temp_centi  = tout_reg;
    assign result.temp_kelvin = kprod[27:19];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            dt_reg    <= '0;
            seen_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            dt_reg    <= dt_next;
            seen_reg  <= seen_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            d1_reg <= d1_in;
        end
        if (state_reg == ST_MUL_T && mul_done) begin
            temp_reg <= TEMP_BASE + {product[50], product[50:31]};
        end
        if (state_reg == ST_MUL_O && mul_done) begin
            off_reg <= {3'b000, coef.c2, 16'h0000} + product[49:15];
        end
        if (state_reg == ST_MUL_P && mul_done) begin
            psh_reg <= product[57:21];
        end
        if (state_reg == ST_CHECK) begin
            press_reg <= press_val[16:0];
            tout_reg  <= temp_reg[14:0];
            ksum_reg  <= ksum[KSUM_W-1:0];
        end
    end

endmodule

>>> rtl/baro_pressure_compensation_unit.sv
`timescale 1ns / 1ps

// Barometric pressure compensation, first order.
// Input stream (s_): one item per measurement pair, raw pressure and raw
// temperature in s_tdata, temperature-valid flag in s_tuser. A valid
// temperature updates the stored difference; otherwise the stored one is reused.
// Result stream (m_): pressure in Pa, temperature in centidegrees and kelvin,
// sent only when both lie inside their windows; otherwise the item is dropped.
// Calibration words sit behind the APB port at byte addresses 0x00..0x14.
// One item is worked on at a time; the next is taken once the previous one is
// through. Each item runs four products on the shared bit-serial multiplier,
// of 16, 16, 16 and 24 steps. An item before any valid temperature is taken
// and yields nothing.
// A result waits in the output register while m_tready is low; the next item
// is still accepted and computed, and waits at its end for the register.
// Synchronous reset clears the calibration words, the stored temperature
// difference, the temperature-seen flag and any pending result.
module baro_pressure_compensation_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,    // pressure_raw [23:0], temp_raw [47:24]
    input  logic        s_tuser,    // temp_valid
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,    // pressure_pa [16:0], temp_centi [31:17],
                                    // temp_kelvin [40:32], zero [47:41]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bpc_pkg::*;

    coef_t                      coef;
    mul_ctrl_t                  mul_ctrl;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic [DATA_W-1:0]          mul_b;
    logic                       mul_done;
    logic [PROD_W-1:0]          product;
    logic                       res_valid;
    logic                       res_ready;
    result_t                    result;

    logic        m_valid_reg, m_valid_next;
    logic [47:0] m_data_reg;

    bpc_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coef    (coef)
    );

    bpc_serial_mul u_mul (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (mul_ctrl),
        .mul_a    (mul_a),
        .mul_b    (mul_b),
        .mul_done (mul_done),
        .product  (product)
    );

    bpc_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .d1_in     (s_tdata[23:0]),
        .d2_in     (s_tdata[47:24]),
        .tv_in     (s_tuser),
        .coef      (coef),
        .mul_ctrl  (mul_ctrl),
        .mul_a     (mul_a),
        .mul_b     (mul_b),
        .mul_done  (mul_done),
        .product   (product),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .result    (result)
    );

    // output register: free when empty or being drained this cycle
    assign res_ready = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_data_reg <= {7'b0000000, result.temp_kelvin, result.temp_centi,
                           result.pressure_pa};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

>>> rtl/bpc_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bpc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);
    logic [16:0]        press;
    logic signed [16:0] temp_ext;
    logic [16:0]        ksum_chk;
    logic [16:0]        kel_x100;
    logic               press_in;
    logic               temp_in;

    assign press    = m_tdata[16:0];
    assign temp_ext = {{2{m_tdata[31]}}, m_tdata[31:17]};
    assign ksum_chk = 17'(temp_ext + 17'sd27365);
    assign kel_x100 = 17'(m_tdata[40:32]) * 17'd100;
    assign press_in = (press > 17'd45000) && (press < 17'd120000);
    assign temp_in  = (temp_ext > -17'sd4000) && (temp_ext < 17'sd8500);

    `BPC_ASSERT_ALWAYS(a_reset_clears_out, !aresetn |=> !m_tvalid)
    `BPC_ASSERT(a_stall_holds, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    `BPC_ASSERT(a_window, m_tvalid |-> press_in && temp_in)
    `BPC_ASSERT(a_kelvin, m_tvalid |-> kel_x100 <= ksum_chk && ksum_chk < kel_x100 + 17'd100)

endmodule

bind baro_pressure_compensation_unit bpc_checker u_bpc_checker (.*);

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import bpc_pkg::*;

    localparam int NUM_CAL = 6;
    localparam int LONG_HOLD = 600;
    localparam int SETTLE_CYCLES = 120;
    localparam int DRAIN_LIMIT = 2000;
    localparam int QUIET_LIMIT = 5000;
    localparam int MAX_LOGGED = 60;

    localparam longint TEMP_REF = 2000;
    localparam longint PRESS_FLOOR = 45000;
    localparam longint PRESS_CEIL = 120000;
    localparam longint TEMP_FLOOR = -4000;
    localparam longint TEMP_CEIL = 8500;
    localparam longint KELVIN_OFFSET = 27365;    // 27315 plus half a degree
    localparam longint CENTI_PER_DEG = 100;

    localparam logic [4:0] ADDR_SPARE_A = 5'h18;
    localparam logic [4:0] ADDR_SPARE_B = 5'h1C;

    // Nominal calibration and one matching measurement pair
    localparam logic [15:0] NOM_C1 = 16'd40127;
    localparam logic [15:0] NOM_C2 = 16'd36924;
    localparam logic [15:0] NOM_C3 = 16'd23317;
    localparam logic [15:0] NOM_C4 = 16'd23282;
    localparam logic [15:0] NOM_C5 = 16'd33464;
    localparam logic [15:0] NOM_C6 = 16'd28312;
    localparam logic [23:0] NOM_D1 = 24'd9085466;
    localparam logic [23:0] NOM_D2 = 24'd8569150;
    localparam logic [23:0] RAW_MAX = 24'hFFFFFF;

    typedef struct {
        logic [23:0] press_raw;
        logic [23:0] temp_raw;
        logic        temp_ok;
    } meas_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;    // pressure_raw [23:0], temp_raw [47:24]
    logic        s_tuser = 1'b0;  // temp_valid
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;         // pressure_pa [16:0], temp_centi [31:17],
                                  // temp_kelvin [40:32], zero [47:41]
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // calibration copy and compensation state
    logic [15:0]         cal_word [NUM_CAL];
    logic signed [25:0]  stored_dt = '0;
    logic                dt_seen = 1'b0;
    longint              gen_dt = 0;

    meas_t   meas_backlog [$];
    result_t readings_due [$];

    int mismatches = 0;
    int items_taken = 0;
    int readings_checked = 0;
    int cal_sets = 0;
    int tx_gap = 0;
    int tx_burst = 0;
    int rx_gap = 0;
    int rx_burst = 0;
    int hold_left = 0;
    logic hold_done = 1'b0;
    logic hold_request = 1'b0;
    int quiet_cycles = 0;

    baro_pressure_compensation_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 aclk = ~aclk;

    initial begin
        foreach (cal_word[i]) cal_word[i] = '0;
    end

    task automatic log_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_LOGGED) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    function automatic longint temp_of(input longint dt);
        return TEMP_REF + ((dt * longint'(cal_word[REG_C6])) >>> 23);
    endfunction

    function automatic longint press_of(input logic [23:0] d1, input longint dt);
        longint sens;
        longint off;
        sens = longint'(cal_word[REG_C1]) * 32768 + ((dt * longint'(cal_word[REG_C3])) >>> 8);
        off = longint'(cal_word[REG_C2]) * 65536 + ((dt * longint'(cal_word[REG_C4])) >>> 7);
        return (((longint'(d1) * sens) >>> 21) - off) >>> 15;
    endfunction

    // Work out the reading a measurement pair should produce, if any
    task automatic compensate_meas(input logic [23:0] d1, input logic [23:0] d2, input logic tv);
        longint  t;
        longint  p;
        longint  k;
        result_t r;
        if (tv) begin
            stored_dt = 26'(longint'(d2) - longint'(cal_word[REG_C5]) * 256);
            dt_seen = 1'b1;
        end
        if (dt_seen) begin
            t = temp_of(longint'(stored_dt));
            p = press_of(d1, longint'(stored_dt));
            if (p > PRESS_FLOOR && p < PRESS_CEIL && t > TEMP_FLOOR && t < TEMP_CEIL) begin
                k = (t + KELVIN_OFFSET) / CENTI_PER_DEG;
                r.pressure_pa = p[16:0];
                r.temp_centi = t[14:0];
                r.temp_kelvin = k[8:0];
                readings_due.push_back(r);
            end
        end
    endtask

    // Smallest D1 whose pressure reaches target at the given dT
    function automatic logic [23:0] d1_for_press(input longint dt, input longint target);
        longint lo;
        longint hi;
        longint mid;
        lo = 0;
        hi = longint'(RAW_MAX);
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (press_of(mid[23:0], dt) >= target) hi = mid;
            else lo = mid + 1;
        end
        return lo[23:0];
    endfunction

    // Smallest D2 whose temperature reaches target
    function automatic logic [23:0] d2_for_temp(input longint target);
        longint lo;
        longint hi;
        longint mid;
        lo = 0;
        hi = longint'(RAW_MAX);
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (temp_of(mid - longint'(cal_word[REG_C5]) * 256) >= target) hi = mid;
            else lo = mid + 1;
        end
        return lo[23:0];
    endfunction

    function automatic int idle_cycles(inout int burst);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            burst = $urandom_range(8, 24);
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    task automatic apb_access(input logic wr, input logic [4:0] addr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic cal_write(input logic [4:0] addr, input logic [31:0] data);
        logic [31:0] unused;
        apb_access(1'b1, addr, data, unused);
        // writes past the last coefficient are dropped
        if (int'(addr[4:2]) < NUM_CAL) cal_word[addr[4:2]] = data[15:0];
    endtask

    task automatic load_cal(input logic [15:0] c1, input logic [15:0] c2, input logic [15:0] c3,
                            input logic [15:0] c4, input logic [15:0] c5, input logic [15:0] c6);
        logic [15:0] words [NUM_CAL];
        logic [31:0] rd;
        reg_idx_t    r;
        words = '{c1, c2, c3, c4, c5, c6};
        r = r.first();
        do begin
            cal_write({r, 2'b00}, {16'h0, words[r]});
            apb_access(1'b0, {r, 2'b00}, '0, rd);
            if (rd != {16'h0, cal_word[r]}) begin
                log_mismatch($sformatf("%s reads %h, want %h", r.name(), rd, cal_word[r]));
            end
            r = r.next();
        end while (r != r.first());
        cal_sets++;
    endtask

    task automatic queue_meas(input logic [23:0] d1, input logic [23:0] d2, input logic tv);
        meas_t m;
        m.press_raw = d1;
        m.temp_raw = d2;
        m.temp_ok = tv;
        if (tv) gen_dt = longint'(d2) - longint'(cal_word[REG_C5]) * 256;
        meas_backlog.push_back(m);
    endtask

    // Mostly pairs aimed at the windows and just beyond them, the rest raw noise
    task automatic queue_mix(input int count, input int noise_pct);
        int          k;
        logic        tv;
        logic [23:0] d1;
        logic [23:0] d2;
        longint      dt;
        @(negedge aclk);
        for (k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                d1 = 24'($urandom);
                d2 = 24'($urandom);
                tv = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 7) == 0) d1 = $urandom_range(0, 1) ? RAW_MAX : 24'h0;
                if ($urandom_range(0, 7) == 0) d2 = $urandom_range(0, 1) ? RAW_MAX : 24'h0;
            end else begin
                // open each set on the stored temperature
                tv = (k != 0) && ($urandom_range(0, 3) != 0);
                d2 = tv ? d2_for_temp(longint'($urandom_range(0, 13700)) - 4600)
                        : 24'($urandom);
                dt = tv ? longint'(d2) - longint'(cal_word[REG_C5]) * 256 : gen_dt;
                d1 = d1_for_press(dt, longint'($urandom_range(40000, 125000)));
            end
            queue_meas(d1, d2, tv);
        end
    endtask

    task automatic wait_quiet();
        int waited;
        waited = 0;
        while ((meas_backlog.size() != 0 || s_tvalid || readings_due.size() != 0)
               && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            if (meas_backlog.size() == 0 && !s_tvalid) waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Sender: present one item at a time, with a random idle gap, at times none, between items
    always @(posedge aclk) begin
        meas_t nxt;
        logic  offer;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            offer = s_tvalid;
            if (s_tvalid && s_tready) begin
                compensate_meas(s_tdata[23:0], s_tdata[47:24], s_tuser);
                items_taken++;
                offer = 1'b0;
                tx_gap = idle_cycles(tx_burst);
            end
            if (!offer && meas_backlog.size() != 0) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else begin
                    nxt = meas_backlog.pop_front();
                    s_tdata <= {nxt.temp_raw, nxt.press_raw};
                    s_tuser <= nxt.temp_ok;
                    offer = 1'b1;
                end
            end
            s_tvalid <= offer;
        end
    end

    // Receiver: compare each reading, stall at random and once for a long stretch
    always @(posedge aclk) begin
        result_t want;
        logic    take;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                readings_checked++;
                if (readings_due.size() == 0) begin
                    log_mismatch($sformatf("reading %0d not expected, data %h",
                                           readings_checked, m_tdata));
                end else begin
                    want = readings_due.pop_front();
                    if (m_tdata[16:0] != want.pressure_pa) begin
                        log_mismatch($sformatf("reading %0d pressure_pa %0d, want %0d",
                                               readings_checked, m_tdata[16:0],
                                               want.pressure_pa));
                    end
                    if (m_tdata[31:17] != want.temp_centi) begin
                        log_mismatch($sformatf("reading %0d temp_centi %0d, want %0d",
                                               readings_checked, $signed(m_tdata[31:17]),
                                               $signed(want.temp_centi)));
                    end
                    if (m_tdata[40:32] != want.temp_kelvin) begin
                        log_mismatch($sformatf("reading %0d temp_kelvin %0d, want %0d",
                                               readings_checked, m_tdata[40:32],
                                               want.temp_kelvin));
                    end
                    if (m_tdata[47:41] != '0) begin
                        log_mismatch($sformatf("reading %0d padding bits %h",
                                               readings_checked, m_tdata[47:41]));
                    end
                end
                rx_gap = idle_cycles(rx_burst);
            end
            if (hold_left > 0) begin
                hold_left--;
                take = 1'b0;
            end else if (hold_request && !hold_done) begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
                take = 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                take = 1'b0;
            end else begin
                take = 1'b1;
            end
            m_tready <= take;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        longint      dt_nom;
        longint      dt_t;
        logic [23:0] d2_t;
        longint      edges [4];
        int          j;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        load_cal(NOM_C1, NOM_C2, NOM_C3, NOM_C4, NOM_C5, NOM_C6);

        @(negedge aclk);
        dt_nom = longint'(NOM_D2) - longint'(cal_word[REG_C5]) * 256;
        // no temperature seen yet: nothing comes out
        queue_meas(NOM_D1, NOM_D2, 1'b0);
        queue_meas(RAW_MAX, 24'h0, 1'b0);
        queue_meas(NOM_D1, NOM_D2, 1'b1);
        // stale temperature reused
        queue_meas(NOM_D1, 24'h0, 1'b0);
        queue_meas(24'h0, NOM_D2, 1'b1);
        queue_meas(RAW_MAX, NOM_D2, 1'b1);
        queue_meas(NOM_D1, 24'h0, 1'b1);
        queue_meas(NOM_D1, RAW_MAX, 1'b1);
        // difference still updated although out of range
        queue_meas(NOM_D1, NOM_D2, 1'b0);
        queue_meas(24'h0, 24'h0, 1'b1);
        queue_meas(RAW_MAX, RAW_MAX, 1'b1);
        edges = '{PRESS_FLOOR, PRESS_FLOOR + 1, PRESS_CEIL - 1, PRESS_CEIL};
        for (j = 0; j < 4; j++) begin
            queue_meas(d1_for_press(dt_nom, edges[j]), NOM_D2, 1'b1);
        end
        edges = '{TEMP_FLOOR, TEMP_FLOOR + 1, TEMP_CEIL - 1, TEMP_CEIL};
        for (j = 0; j < 4; j++) begin
            d2_t = d2_for_temp(edges[j]);
            dt_t = longint'(d2_t) - longint'(cal_word[REG_C5]) * 256;
            queue_meas(d1_for_press(dt_t, 80000), d2_t, 1'b1);
        end

        @(posedge aclk);
        hold_request <= 1'b1;
        queue_mix(400, 20);

        wait_quiet();
        cal_write(ADDR_SPARE_A, 32'hFFFF_FFFF);
        cal_write(ADDR_SPARE_B, 32'h0000_5A5A);
        load_cal(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom), 16'($urandom));
        queue_mix(150, 25);

        wait_quiet();
        load_cal(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_mix(120, 25);

        wait_quiet();
        load_cal(16'hFFFF, 16'h0, 16'h0, 16'hFFFF, 16'h0, 16'hFFFF);
        queue_mix(100, 25);

        wait_quiet();
        load_cal(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom), 16'($urandom));
        queue_mix(150, 25);

        wait_quiet();
        load_cal(NOM_C1, NOM_C2, 16'($urandom), NOM_C4, NOM_C5, 16'h1000);
        queue_mix(150, 20);

        wait_quiet();
        load_cal(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
        queue_mix(60, 30);

        wait_quiet();
        if (readings_due.size() != 0) begin
            log_mismatch($sformatf("%0d expected readings never arrived", readings_due.size()));
        end
        $display("Sent %0d measurement pairs across %0d calibration sets, %0d readings compared.",
                 items_taken, cal_sets, readings_checked);
        $display("Mismatches: %0d", mismatches);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
